// ===== rtl/core/sfip_pkg.sv =====
// Shared types and constants for the sentence field integer parser.
// Used by sfip_kw_match, sfip_num_acc and sentence_field_integer_parser.
package sfip_pkg;

    localparam int CHAR_W    = 8;
    localparam int KW_BYTES  = 8;
    localparam int KW_W      = KW_BYTES * CHAR_W;
    localparam int KLEN_W    = 4;
    localparam int TLEN_W    = 7;
    localparam int VALUE_W   = 32;

    localparam logic [KLEN_W-1:0] KEYWORD_MAX = 4'd8;
    localparam logic [TLEN_W-1:0] TOKEN_CAP   = 7'd100;

    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    localparam logic CFG_KEYWORD_BYTES  = 1'b0;
    localparam logic CFG_KEYWORD_LENGTH = 1'b1;

    localparam logic [VALUE_W-1:0] MAG_NEG_LIMIT = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MAG_POS_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        NUM_EXPECT = 2'd0,
        NUM_SIGN   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_STOP   = 2'd3
    } num_phase_t;

    typedef struct packed {
        num_phase_t           phase;
        logic                 negative;
        logic [VALUE_W-1:0]   magnitude;
        logic                 overflow;
    } num_state_t;

    localparam num_state_t NUM_CLEAR = '{
        phase: NUM_EXPECT, negative: 1'b0, magnitude: '0, overflow: 1'b0
    };

endpackage

// ===== rtl/core/sfip_kw_match.sv =====
// Keyword suffix compare: does the token end in the configured keyword.
// Depends on sfip_pkg.
module sfip_kw_match (
    input  logic [sfip_pkg::KW_W-1:0]   recent,
    input  logic [sfip_pkg::TLEN_W-1:0] tok_len,
    input  logic [sfip_pkg::KW_W-1:0]   kw_bytes,
    input  logic [sfip_pkg::KLEN_W-1:0] kw_len,
    output logic                        hit
);

    logic [sfip_pkg::KLEN_W-1:0] k;
    logic [sfip_pkg::KW_BYTES:0] match_k;

    always_comb begin
        k = (kw_len > sfip_pkg::KEYWORD_MAX) ? sfip_pkg::KEYWORD_MAX : kw_len;
        match_k = '1;
        for (int n = 1; n <= sfip_pkg::KW_BYTES; n++) begin
            for (int i = 0; i < n; i++) begin
                if (kw_bytes[8*i +: 8] != recent[8*(n-1-i) +: 8]) begin
                    match_k[n] = 1'b0;
                end
            end
        end
        hit = (tok_len >= {3'b000, k}) && match_k[k];
    end

endmodule

// ===== rtl/core/sfip_num_acc.sv =====
// Signed decimal accumulator: one character step of the number scan.
// Depends on sfip_pkg.
module sfip_num_acc (
    input  logic [sfip_pkg::CHAR_W-1:0] ch,
    input  sfip_pkg::num_state_t        cur,
    output sfip_pkg::num_state_t        nxt
);

    logic        digit;
    logic [35:0] prod;

    always_comb begin
        nxt   = cur;
        digit = (ch >= sfip_pkg::CHAR_ZERO) && (ch <= sfip_pkg::CHAR_NINE);
        prod  = ({4'b0000, cur.magnitude} << 3) + ({4'b0000, cur.magnitude} << 1)
              + {32'd0, ch[3:0]};
        priority if (cur.phase == sfip_pkg::NUM_STOP) begin
            nxt = cur;
        end else if (digit) begin
            if (prod > {4'b0000, sfip_pkg::MAG_NEG_LIMIT}) begin
                nxt.overflow = 1'b1;
            end else begin
                nxt.magnitude = prod[31:0];
            end
            nxt.phase = sfip_pkg::NUM_DIGITS;
        end else if (cur.phase == sfip_pkg::NUM_EXPECT &&
                     (ch == sfip_pkg::CHAR_PLUS || ch == sfip_pkg::CHAR_MINUS)) begin
            nxt.negative = (ch == sfip_pkg::CHAR_MINUS);
            nxt.phase    = sfip_pkg::NUM_SIGN;
        end else begin
            if (cur.phase != sfip_pkg::NUM_DIGITS) begin
                nxt.overflow = 1'b1;
            end
            nxt.phase = sfip_pkg::NUM_STOP;
        end
    end

endmodule

// ===== rtl/core/sentence_field_integer_parser.sv =====
// Top level of the sentence field integer parser: input register, token state,
// result register. Depends on sfip_pkg, sfip_kw_match and sfip_num_acc.
//
//  channel | ports                        | transaction
//  --------+------------------------------+-------------------------------
//  s_      | s_valid s_ready s_character  | one received byte
//  m_      | m_valid m_ready m_orientation| one parsed signed integer
//  cfg_    | cfg_we cfg_index cfg_wdata   | register write, no wait
//
// One character per cycle while the parse stage is not stalled: a byte sits in
// the input register, is parsed there against the token state, and a result is
// registered into the output register as it advances; m_valid is that register.
// aresetn is synchronous, active low; keyword length resets to one.
// A held result stalls the parse stage only when a new one is due behind it.
module sentence_field_integer_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sfip_pkg::CHAR_W-1:0]   s_character,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sfip_pkg::VALUE_W-1:0] m_orientation,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [sfip_pkg::KW_W-1:0]     cfg_wdata
);

    logic [sfip_pkg::KW_W-1:0]   kw_bytes_reg;
    logic [sfip_pkg::KLEN_W-1:0] kw_len_reg;

    logic                        in_valid_reg;
    logic [sfip_pkg::CHAR_W-1:0] char_reg;

    logic                        sss_reg, sss_next;
    logic                        matched_reg, matched_next;
    logic [1:0]                  field_reg, field_next;
    logic [sfip_pkg::TLEN_W-1:0] tlen_reg, tlen_next;
    logic [sfip_pkg::KW_W-1:0]   recent_reg, recent_next;
    logic                        hit_reg, hit_next;
    sfip_pkg::num_state_t        num_reg, num_next, num_step;

    logic                        m_valid_reg;
    logic [sfip_pkg::VALUE_W-1:0] m_data_reg;

    logic                        advance;
    logic                        emit;
    logic                        fits;
    logic [sfip_pkg::VALUE_W-1:0] value;
    logic [sfip_pkg::KW_W-1:0]   app_recent;
    logic [sfip_pkg::TLEN_W-1:0] app_len;
    logic                        app_hit;

    assign advance   = in_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_orientation = m_data_reg;

    assign app_recent = {recent_reg[sfip_pkg::KW_W-9:0], char_reg};
    assign app_len    = tlen_reg + 7'd1;

    sfip_kw_match u_kw (
        .recent   (app_recent),
        .tok_len  (app_len),
        .kw_bytes (kw_bytes_reg),
        .kw_len   (kw_len_reg),
        .hit      (app_hit)
    );

    sfip_num_acc u_num (
        .ch  (char_reg),
        .cur (num_reg),
        .nxt (num_step)
    );

    always_comb begin
        sss_next     = sss_reg;
        matched_next = matched_reg;
        field_next   = field_reg;
        tlen_next    = tlen_reg;
        recent_next  = recent_reg;
        hit_next     = hit_reg;
        num_next     = num_reg;
        emit         = 1'b0;
        fits  = num_reg.negative ? (num_reg.magnitude <= sfip_pkg::MAG_NEG_LIMIT)
                                 : (num_reg.magnitude <= sfip_pkg::MAG_POS_LIMIT);
        value = num_reg.negative ? (32'd0 - num_reg.magnitude) : num_reg.magnitude;
        priority if (char_reg == sfip_pkg::CHAR_DOLLAR) begin
            sss_next = 1'b1;
        end else if (char_reg != sfip_pkg::CHAR_COMMA) begin
            if (tlen_reg < sfip_pkg::TOKEN_CAP) begin
                recent_next = app_recent;
                tlen_next   = app_len;
                hit_next    = hit_reg || app_hit;
                num_next    = num_step;
            end
        end else if (tlen_reg != '0) begin
            if (sss_reg) begin
                field_next   = 2'd0;
                matched_next = hit_reg || (kw_len_reg == '0);
                sss_next     = 1'b0;
            end else begin
                emit = matched_reg && (field_reg == 2'd0) && !num_reg.overflow &&
                       (num_reg.phase == sfip_pkg::NUM_DIGITS ||
                        num_reg.phase == sfip_pkg::NUM_STOP) && fits;
                if (field_reg != 2'd2) begin
                    field_next = field_reg + 2'd1;
                end
            end
            tlen_next   = '0;
            recent_next = '0;
            hit_next    = 1'b0;
            num_next    = sfip_pkg::NUM_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_bytes_reg <= '0;
            kw_len_reg   <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sfip_pkg::CFG_KEYWORD_BYTES:  kw_bytes_reg <= cfg_wdata;
                sfip_pkg::CFG_KEYWORD_LENGTH: kw_len_reg   <= cfg_wdata[3:0];
                default:                      kw_len_reg   <= kw_len_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_character;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sss_reg     <= 1'b0;
            matched_reg <= 1'b0;
            field_reg   <= 2'd0;
            tlen_reg    <= '0;
            recent_reg  <= '0;
            hit_reg     <= 1'b0;
            num_reg     <= sfip_pkg::NUM_CLEAR;
        end else if (advance) begin
            sss_reg     <= sss_next;
            matched_reg <= matched_next;
            field_reg   <= field_next;
            tlen_reg    <= tlen_next;
            recent_reg  <= recent_next;
            hit_reg     <= hit_next;
            num_reg     <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_data_reg <= value;
        end
    end

    a_field_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        field_reg != 2'd3)
        else $error("field count passed saturation");

    a_token_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        tlen_reg <= sfip_pkg::TOKEN_CAP)
        else $error("token length beyond cap");

    a_num_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        num_reg.phase == sfip_pkg::NUM_EXPECT |->
            (num_reg.magnitude == '0 && !num_reg.negative && !num_reg.overflow))
        else $error("number state dirty before first character");

    a_emit_comma: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |-> (char_reg == sfip_pkg::CHAR_COMMA && !sss_reg))
        else $error("result without closing comma of data token");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> m_valid)
        else $error("result lost at output register");

endmodule

// ===== tb/sentence_field_integer_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sentence_field_integer_parser: drives sentence
// bytes over the s_ channel, predicts orientations and checks the m_ channel.
// Depends on sfip_pkg and the sentence_field_integer_parser RTL.
module sentence_field_integer_parser_test;

    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [sfip_pkg::CHAR_W-1:0]         s_character;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [sfip_pkg::VALUE_W-1:0] m_orientation;
    logic                                cfg_we;
    logic                                cfg_index;
    logic [sfip_pkg::KW_W-1:0]           cfg_wdata;

    sentence_field_integer_parser DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_orientation (m_orientation),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // parser state mirror
    logic [sfip_pkg::KW_W-1:0]    kw_bytes;
    logic [sfip_pkg::KLEN_W-1:0]  kw_len;
    logic                         in_sentence;
    logic                         cmd_matched;
    logic [1:0]                   field_cnt;
    logic [sfip_pkg::TLEN_W-1:0]  tok_len;
    logic [sfip_pkg::KW_W-1:0]    tail_chars;
    logic                         kw_seen;
    sfip_pkg::num_phase_t         num_phase;
    logic                         num_neg;
    logic [sfip_pkg::VALUE_W-1:0] num_mag;
    logic                         num_bad;

    logic signed [sfip_pkg::VALUE_W-1:0] orient_expected[$];
    logic signed [sfip_pkg::VALUE_W-1:0] orient_want;

    int errors          = 0;
    int chars_sent      = 0;
    int results_checked = 0;
    int cycles          = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_left       = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sentence_field_integer_parser: mismatch");
            $finish;
        end
    end

    // result checker and receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (orient_expected.size() == 0) begin
                $error("orientation: expected none, got %0d", m_orientation);
                errors++;
            end else begin
                orient_want = orient_expected.pop_front();
                results_checked++;
                if (m_orientation !== orient_want) begin
                    $error("orientation: expected %0d, got %0d", orient_want, m_orientation);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic keyword_at_tail();
        int unsigned k;
        k = 32'((kw_len > sfip_pkg::KEYWORD_MAX) ? sfip_pkg::KEYWORD_MAX : kw_len);
        if (tok_len < k) return 1'b0;
        for (int i = 0; i < k; i++)
            if (kw_bytes[sfip_pkg::CHAR_W*i +: sfip_pkg::CHAR_W] !=
                tail_chars[sfip_pkg::CHAR_W*(k-1-i) +: sfip_pkg::CHAR_W])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_token();
        tok_len    = '0;
        tail_chars = '0;
        kw_seen    = 1'b0;
        num_phase  = sfip_pkg::NUM_EXPECT;
        num_neg    = 1'b0;
        num_mag    = '0;
        num_bad    = 1'b0;
    endtask

    task automatic number_step(input logic [sfip_pkg::CHAR_W-1:0] c);
        logic [63:0] grown;
        if (num_phase == sfip_pkg::NUM_STOP) return;
        if (c >= sfip_pkg::CHAR_ZERO && c <= sfip_pkg::CHAR_NINE) begin
            grown = num_mag * 64'd10 + 64'(c - sfip_pkg::CHAR_ZERO);
            if (grown > 64'h8000_0000) num_bad = 1'b1;
            else num_mag = grown[sfip_pkg::VALUE_W-1:0];
            num_phase = sfip_pkg::NUM_DIGITS;
        end else if (num_phase == sfip_pkg::NUM_EXPECT &&
                     (c == sfip_pkg::CHAR_PLUS || c == sfip_pkg::CHAR_MINUS)) begin
            num_neg   = (c == sfip_pkg::CHAR_MINUS);
            num_phase = sfip_pkg::NUM_SIGN;
        end else begin
            if (num_phase != sfip_pkg::NUM_DIGITS) num_bad = 1'b1;
            num_phase = sfip_pkg::NUM_STOP;
        end
    endtask

    task automatic parse_char(input logic [sfip_pkg::CHAR_W-1:0] c);
        logic fits;
        if (c == sfip_pkg::CHAR_DOLLAR) begin
            in_sentence = 1'b1;
        end else if (c != sfip_pkg::CHAR_COMMA) begin
            if (tok_len < sfip_pkg::TOKEN_CAP) begin
                tail_chars = {tail_chars[sfip_pkg::KW_W-sfip_pkg::CHAR_W-1:0], c};
                tok_len++;
                if (keyword_at_tail()) kw_seen = 1'b1;
                number_step(c);
            end
        end else if (tok_len != 0) begin
            if (in_sentence) begin
                field_cnt   = 2'd0;
                cmd_matched = kw_seen || (kw_len == 0);
                in_sentence = 1'b0;
            end else begin
                if (cmd_matched && field_cnt == 0 && !num_bad &&
                    (num_phase == sfip_pkg::NUM_DIGITS ||
                     num_phase == sfip_pkg::NUM_STOP)) begin
                    fits = num_neg ? (num_mag <= sfip_pkg::MAG_NEG_LIMIT)
                                   : (num_mag <= sfip_pkg::MAG_POS_LIMIT);
                    if (fits) begin
                        orient_expected.push_back(num_neg ? 32'd0 - num_mag : num_mag);
                    end
                end
                if (field_cnt < 2) field_cnt++;
            end
            clear_token();
        end
    endtask

    task automatic send_char(input logic [sfip_pkg::CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // sender stops and waits for every pending orientation plus pipeline slack
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (orient_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [sfip_pkg::KW_W-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == sfip_pkg::CFG_KEYWORD_BYTES) kw_bytes = data;
        else kw_len = data[sfip_pkg::KLEN_W-1:0];
    endtask

    function automatic logic [sfip_pkg::CHAR_W-1:0] filler_char();
        logic [sfip_pkg::CHAR_W-1:0] c;
        do c = 8'($urandom_range(255));
        while (c == sfip_pkg::CHAR_DOLLAR || c == sfip_pkg::CHAR_COMMA);
        return c;
    endfunction

    function automatic logic [sfip_pkg::CHAR_W-1:0] noise_char();
        case ($urandom_range(4))
            0: return sfip_pkg::CHAR_DOLLAR;
            1: return sfip_pkg::CHAR_COMMA;
            2: return sfip_pkg::CHAR_ZERO + 8'($urandom_range(9));
            3: return sfip_pkg::CHAR_MINUS;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [sfip_pkg::KW_W-1:0] random_keyword();
        logic [sfip_pkg::KW_W-1:0] kw;
        for (int i = 0; i < sfip_pkg::KW_BYTES; i++)
            kw[sfip_pkg::CHAR_W*i +: sfip_pkg::CHAR_W] = filler_char();
        return kw;
    endfunction

    task automatic send_command_token();
        int unsigned k;
        int unsigned r;
        k = 32'((kw_len > sfip_pkg::KEYWORD_MAX) ? sfip_pkg::KEYWORD_MAX : kw_len);
        r = $urandom_range(99);
        // keyword beyond the token cap is dropped
        if (r < 5) repeat (sfip_pkg::TOKEN_CAP + $urandom_range(3)) send_char(filler_char());
        repeat ($urandom_range(3)) send_char(filler_char());
        if (r < 75) begin
            for (int i = 0; i < k; i++)
                send_char(kw_bytes[sfip_pkg::CHAR_W*i +: sfip_pkg::CHAR_W]);
        end else begin
            repeat ($urandom_range(1, 4)) send_char(filler_char());
        end
        repeat ($urandom_range(2)) send_char(filler_char());
    endtask

    task automatic send_number_token();
        int unsigned kind;
        longint unsigned mag;
        string sign;
        string digits;
        string pad;
        kind = $urandom_range(99);
        case ($urandom_range(5))
            0: mag = $urandom_range(9);
            1: mag = $urandom_range(99999);
            2: mag = $urandom;
            3: mag = 64'd2147483647 + $urandom_range(1);
            4: mag = 64'd4294967295 - $urandom_range(3);
            default: mag = $urandom_range(999);
        endcase
        case ($urandom_range(2))
            0: sign = "";
            1: sign = "+";
            default: sign = "-";
        endcase
        digits = $sformatf("%0d", mag);
        pad = "";
        if (kind < 10) begin
            digits = {"000", digits};
        end else if (kind < 18) begin
            if ($urandom_range(1)) digits = {digits, ".5"};
            else digits = {digits, "x"};
        end else if (kind < 24) begin
            digits = {digits, "123"};
        end else if (kind < 30) begin
            if ($urandom_range(1)) digits = "";
            else digits = "N7";
        end else if (kind < 33) begin
            repeat (96 + $urandom_range(6)) pad = {pad, "0"};
            digits = {pad, $sformatf("%0d", $urandom_range(99999))};
        end
        send_text({sign, digits});
    endtask

    task automatic send_sentence();
        // stray characters before the dollar join the command token
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) send_char(filler_char());
        send_char(sfip_pkg::CHAR_DOLLAR);
        send_command_token();
        send_char(sfip_pkg::CHAR_COMMA);
        if ($urandom_range(9) == 0) send_char(sfip_pkg::CHAR_COMMA);
        send_number_token();
        send_char(sfip_pkg::CHAR_COMMA);
        repeat ($urandom_range(2)) begin
            send_number_token();
            send_char(sfip_pkg::CHAR_COMMA);
        end
    endtask

    task automatic test_reset_keyword();
        send_text("5,");
        send_char(sfip_pkg::CHAR_DOLLAR);
        send_char(8'h00);
        send_text(",7,-0,");
    endtask

    task automatic test_number_limits();
        write_reg(sfip_pkg::CFG_KEYWORD_BYTES, 64'h41);
        write_reg(sfip_pkg::CFG_KEYWORD_LENGTH, 64'd1);
        send_text("$A,-2147483648,$xAy,2147483647,$A,2147483648,$A,-,$A,+12x,$B,9,");
    endtask

    task automatic test_empty_keyword();
        write_reg(sfip_pkg::CFG_KEYWORD_LENGTH, 64'd0);
        send_text("$Q,-9,");
    endtask

    task automatic test_keyword_change_mid_token();
        write_reg(sfip_pkg::CFG_KEYWORD_BYTES, 64'h41);
        write_reg(sfip_pkg::CFG_KEYWORD_LENGTH, 64'd1);
        send_text("$A");
        write_reg(sfip_pkg::CFG_KEYWORD_BYTES, 64'h5A);
        send_text("Y,3,");
    endtask

    task automatic test_sender_pause();
        send_text("$Z,4,$Z,1");
        wait_idle();
        send_text("5,");
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        hold_left = 150;
        for (int i = 0; i < 10; i++) send_text($sformatf("$Z,%0d,", i * 37 - 100));
        wait_idle();
        send_idle_pct = 22;
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct,
                                       input logic [sfip_pkg::KW_W-1:0] kw,
                                       input logic [sfip_pkg::KLEN_W-1:0] len);
        logic [sfip_pkg::KW_W-1:0] len_word;
        int first_char;
        len_word = {$urandom, $urandom};
        len_word[sfip_pkg::KLEN_W-1:0] = len;
        write_reg(sfip_pkg::CFG_KEYWORD_BYTES, kw);
        write_reg(sfip_pkg::CFG_KEYWORD_LENGTH, len_word);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        first_char   = chars_sent;
        while (chars_sent - first_char < 280) begin
            if ($urandom_range(9) == 0) repeat ($urandom_range(1, 8)) send_char(noise_char());
            else send_sentence();
        end
        wait_idle();
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_character <= '0;
        m_ready     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= sfip_pkg::CFG_KEYWORD_BYTES;
        cfg_wdata   <= '0;
        kw_bytes    = '0;
        kw_len      = 4'd1;
        in_sentence = 1'b0;
        cmd_matched = 1'b0;
        field_cnt   = 2'd0;
        clear_token();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 50;
        test_reset_keyword();
        test_number_limits();
        test_empty_keyword();
        test_keyword_change_mid_token();
        test_sender_pause();
        test_receiver_stall();
        test_random_traffic(22, 50, random_keyword(), 4'd5);
        test_random_traffic(50, 22, {sfip_pkg::KW_W{1'b1}}, 4'd15);
        test_random_traffic(0, 0, random_keyword(), 4'd8);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (orient_expected.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("%0d characters sent, %0d orientations checked", chars_sent, results_checked);
        $display("keyword lengths 0, 1, 5, 8 and 15, stalls on both channels, mid-token writes");
        if (errors == 0) begin
            $display("sentence_field_integer_parser: match");
        end else begin
            $display("sentence_field_integer_parser: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sfip_pkg.sv
rtl/core/sfip_kw_match.sv
rtl/core/sfip_num_acc.sv
rtl/core/sentence_field_integer_parser.sv
tb/sentence_field_integer_parser_test.sv
